// ===== design/sha1_pkg.sv =====
// Shared types and constants of the SHA-1 hash engine.
package sha1_pkg;

    // Initial chaining value.
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] LEN_LAST   = 3'd7;

    // Input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } out_item_t;

    // Source of the byte shifted into the block register.
    typedef enum logic [1:0] {
        SRC_MSG,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       shift_en;
        byte_src_t  byte_src;
        logic [2:0] len_idx;
        logic       count_len;
        logic       load_work;
        logic       round_en;
        logic [6:0] round_idx;
        logic       update;
        logic       reinit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;
    } dp_status_t;

endpackage

// ===== design/sha1_datapath.sv =====
// Datapath of the SHA-1 engine: block shift register, rounds, chaining words, length.
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  logic [7:0] data_byte,
    output dp_status_t status,
    output out_item_t  result
);

    logic [511:0] blk_reg, blk_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [31:0]  h_reg [5];
    logic [31:0]  h_next [5];
    logic [63:0]  len_reg, len_next;
    logic [5:0]   fill_reg, fill_next;

    logic [7:0]   in_byte;
    logic [7:0]   len_byte;
    logic [31:0]  w0, w2, w8, w13, w_sched, w_t;
    logic [31:0]  f_val, k_val, t_sum;
    logic [1:0]   grp;

    // Pick the byte to shift into the block.
    always_comb
    begin
        len_byte = 8'(len_reg >> {3'(LEN_LAST - cmd.len_idx), 3'b000});
        unique case (cmd.byte_src)
            SRC_MSG:  in_byte = data_byte;
            SRC_MARK: in_byte = PAD_MARK;
            SRC_ZERO: in_byte = 8'h00;
            SRC_LEN:  in_byte = len_byte;
            default:  in_byte = 8'h00;
        endcase
    end

    // Message schedule taps over the sixteen-word window (word 0 oldest).
    assign w0      = blk_reg[511:480];
    assign w2      = blk_reg[447:416];
    assign w8      = blk_reg[255:224];
    assign w13     = blk_reg[95:64];
    assign w_sched = w13 ^ w8 ^ w2 ^ w0;
    assign w_t     = (cmd.round_idx < 7'd16) ? w0 : {w_sched[30:0], w_sched[31]};

    // Round function and constant by group of twenty rounds.
    always_comb
    begin
        if (cmd.round_idx < 7'd20)
            grp = 2'd0;
        else if (cmd.round_idx < 7'd40)
            grp = 2'd1;
        else if (cmd.round_idx < 7'd60)
            grp = 2'd2;
        else
            grp = 2'd3;
        unique case (grp)
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd2:    f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            default: f_val = b_reg ^ c_reg ^ d_reg;
        endcase
        k_val = ROUND_K[grp];
        t_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_t;
    end

    // Next-state logic for all datapath registers.
    always_comb
    begin
        blk_next  = blk_reg;
        fill_next = fill_reg;
        len_next  = len_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        h_next    = h_reg;

        // Shift a byte in and advance the fill count.
        if (cmd.shift_en)
        begin
            blk_next  = {blk_reg[503:0], in_byte};
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.count_len)
            len_next = len_reg + 64'd8;

        // Load working words from the chaining value.
        if (cmd.load_work)
        begin
            a_next = h_reg[0];
            b_next = h_reg[1];
            c_next = h_reg[2];
            d_next = h_reg[3];
            e_next = h_reg[4];
        end

        // Run one round and roll the schedule window.
        if (cmd.round_en)
        begin
            a_next   = t_sum;
            b_next   = a_reg;
            c_next   = {b_reg[1:0], b_reg[31:2]};
            d_next   = c_reg;
            e_next   = d_reg;
            blk_next = {blk_reg[479:0], w_t};
        end

        // Fold the working words into the chaining value.
        if (cmd.update)
        begin
            h_next[0] = h_reg[0] + a_reg;
            h_next[1] = h_reg[1] + b_reg;
            h_next[2] = h_reg[2] + c_reg;
            h_next[3] = h_reg[3] + d_reg;
            h_next[4] = h_reg[4] + e_reg;
        end

        // Restart for the next message.
        if (cmd.reinit)
        begin
            h_next   = H_INIT;
            len_next = 64'd0;
        end
    end

    // Hold control and chaining state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg    <= H_INIT;
            len_reg  <= 64'd0;
            fill_reg <= 6'd0;
        end
        else
        begin
            h_reg    <= h_next;
            len_reg  <= len_next;
            fill_reg <= fill_next;
        end
    end

    // Hold block and working words.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    assign status.fill = fill_reg;

    assign result.digest_word0 = h_reg[0];
    assign result.digest_word1 = h_reg[1];
    assign result.digest_word2 = h_reg[2];
    assign result.digest_word3 = h_reg[3];
    assign result.digest_word4 = h_reg[4];

endmodule

// ===== design/sha1_ctrl.sv =====
// Controller of the SHA-1 engine: intake, compression sequencing and padding.
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  in_item_t   in_item,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [6:0] round_reg, round_next;
    logic [2:0] lidx_reg, lidx_next;

    // Sequence commands and next state.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        round_next = round_reg;
        lidx_next  = lidx_reg;
        cmd        = '0;
        cmd.byte_src  = SRC_MSG;
        cmd.round_idx = round_reg;
        cmd.len_idx   = lidx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (in_item.has_byte)
                    begin
                        cmd.shift_en  = 1'b1;
                        cmd.count_len = 1'b1;
                        if (status.fill == FILL_LAST)
                        begin
                            cmd.load_work = 1'b1;
                            state_next    = ST_ROUND;
                            ret_next      = in_item.last_item ? ST_PAD_MARK : ST_IDLE;
                        end
                        else if (in_item.last_item)
                            state_next = ST_PAD_MARK;
                    end
                    else if (in_item.last_item)
                        state_next = ST_PAD_MARK;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (round_reg == ROUND_LAST)
                begin
                    round_next = 7'd0;
                    state_next = ST_UPDATE;
                end
                else
                    round_next = round_reg + 7'd1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ret_reg;
            end
            ST_PAD_MARK:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_src = SRC_MARK;
                state_next   = ST_PAD_ZERO;
                if (status.fill == FILL_LAST)
                begin
                    cmd.load_work = 1'b1;
                    state_next    = ST_ROUND;
                    ret_next      = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (status.fill == FILL_LEN)
                    state_next = ST_PAD_LEN;
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_src = SRC_ZERO;
                    if (status.fill == FILL_LAST)
                    begin
                        cmd.load_work = 1'b1;
                        state_next    = ST_ROUND;
                        ret_next      = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_src = SRC_LEN;
                if (lidx_reg == LEN_LAST)
                begin
                    lidx_next     = 3'd0;
                    cmd.load_work = 1'b1;
                    state_next    = ST_ROUND;
                    ret_next      = ST_EMIT;
                end
                else
                    lidx_next = lidx_reg + 3'd1;
            end
            ST_EMIT:
            begin
                cmd.reinit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold state, return point and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            round_reg <= 7'd0;
            lidx_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            lidx_reg  <= lidx_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_EMIT);

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("engine not idle after digest transfer");

    a_full_block_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_item.has_byte && status.fill == FILL_LAST)
        |=> state_reg == ST_ROUND)
        else $error("full block did not start compression");

    a_len_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD_LEN) |-> (status.fill >= FILL_LEN))
        else $error("length bytes outside block tail");

    a_round_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROUND) |-> (round_reg == 7'd0))
        else $error("round counter not cleared outside rounds");

endmodule

// ===== design/sha1_hash_engine_top.sv =====
// Top level of the SHA-1 hash engine.
//
// Input: an item (one message byte with has_byte, and last_item) transfers at a
// rising edge where start is high and busy is low. An item with has_byte low
// and last_item high ends the message as it stands, also an empty one.
// Output: the 160-bit digest appears on result for exactly one cycle, marked
// by done, and transfers at the edge that ends that cycle. The receiver cannot
// stall; it must take the digest when done is high.
// Timing: a byte that does not complete a block leaves the engine idle. The 64th byte
// of a block starts the compression, which runs one round per cycle in a
// single shared round unit: busy stays high through the 80 rounds and the
// chaining-word update. The last item then pads byte by byte through the
// same block shift register: the marker, the zero bytes and the length bytes
// (in the current block when they fit, spilling into a second block when fill
// is 56 or more), a step with no shift to switch to the length bytes, one
// compression per padded block (one or two), and one cycle with done high.
// No item is taken while busy is high, so intake stops during each compression.
// Reset: the chaining words return to the initial hash value, length and fill
// count clear, and the engine is idle; there is no clearing pass.
module sha1_hash_engine_top
    import sha1_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  in_item,
    output logic      done,
    output out_item_t result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sha1_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .in_item (in_item),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    sha1_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (in_item.data_byte),
        .status    (status),
        .result    (result)
    );

endmodule

// ===== tb/sha1_digest_sb_pkg.sv =====
// Scoreboard class that predicts and checks SHA-1 digests.
package sha1_digest_sb_pkg;

    import sha1_pkg::*;

    class sha1_digest_scoreboard;

        logic [31:0] chain [5];
        logic [7:0]  blk_bytes [64];
        logic [63:0] bit_len;
        out_item_t   digest_q [$];
        int unsigned mismatches;
        int unsigned digests_seen;

        function new();
            foreach (blk_bytes[i])
            begin
                blk_bytes[i] = 8'h00;
            end
            mismatches   = 0;
            digests_seen = 0;
            restart_chain();
        endfunction

        // Return to the initial hash value with an empty message.
        function void restart_chain();
            foreach (chain[i])
            begin
                chain[i] = H_INIT[i];
            end
            bit_len = '0;
        endfunction

        // Run the 80 rounds over the current block and fold into the chain.
        function void compress();
            logic [31:0] w [80];
            logic [31:0] a, b, c, d, e, f, t, x;
            for (int i = 0; i < 16; i++)
            begin
                w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
            end
            for (int i = 16; i < 80; i++)
            begin
                x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
                w[i] = {x[30:0], x[31]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int r = 0; r < 80; r++)
            begin
                if (r < 20)
                begin
                    f = (b & c) | (~b & d);
                end
                else if (r < 40 || r >= 60)
                begin
                    f = b ^ c ^ d;
                end
                else
                begin
                    f = (b & c) | (b & d) | (c & d);
                end
                t = {a[26:0], a[31:27]} + f + e + ROUND_K[r / 20] + w[r];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // Absorb one transferred input item; on end of message queue its digest.
        function void note_item(in_item_t it);
            int        fill;
            out_item_t dig;
            if (it.has_byte)
            begin
                fill            = bit_len[8:3];
                blk_bytes[fill] = it.data_byte;
                bit_len        += 64'd8;
                if (fill == FILL_LAST)
                begin
                    compress();
                end
            end
            if (!it.last_item)
            begin
                return;
            end
            // Pad with the marker, zeros and the big-endian bit length.
            fill            = bit_len[8:3];
            blk_bytes[fill] = PAD_MARK;
            for (int j = fill + 1; j < 64; j++)
            begin
                blk_bytes[j] = 8'h00;
            end
            if (fill >= FILL_LEN)
            begin
                compress();
                foreach (blk_bytes[j])
                begin
                    blk_bytes[j] = 8'h00;
                end
            end
            for (int j = 0; j < 8; j++)
            begin
                blk_bytes[63-j] = bit_len[8*j +: 8];
            end
            compress();
            dig.digest_word0 = chain[0];
            dig.digest_word1 = chain[1];
            dig.digest_word2 = chain[2];
            dig.digest_word3 = chain[3];
            dig.digest_word4 = chain[4];
            digest_q.push_back(dig);
            restart_chain();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        // Compare a transferred digest word by word against the oldest one pending.
        task check_digest(out_item_t got);
            out_item_t   exp_dig;
            logic [31:0] gw [5];
            logic [31:0] ew [5];
            digests_seen++;
            if (digest_q.size() == 0)
            begin
                report($sformatf("digest %h with none pending", got));
                return;
            end
            exp_dig = digest_q.pop_front();
            gw = '{got.digest_word0, got.digest_word1, got.digest_word2,
                   got.digest_word3, got.digest_word4};
            ew = '{exp_dig.digest_word0, exp_dig.digest_word1, exp_dig.digest_word2,
                   exp_dig.digest_word3, exp_dig.digest_word4};
            for (int i = 0; i < 5; i++)
            begin
                if (gw[i] !== ew[i])
                begin
                    report($sformatf("digest %0d word%0d got %h want %h",
                                     digests_seen, i, gw[i], ew[i]));
                end
            end
        endtask

        function int pending();
            return digest_q.size();
        endfunction

        // Flag digests that were predicted but never came out.
        task check_drained();
            if (digest_q.size() != 0)
            begin
                report($sformatf("%0d digests never arrived", digest_q.size()));
            end
        endtask

    endclass

endpackage

// ===== tb/tb_sha1_hash_engine_top.sv =====
// Testbench top for the SHA-1 hash engine: directed and random messages.
module tb_sha1_hash_engine_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sha1_pkg::*;
    import sha1_digest_sb_pkg::*;

    localparam int ITEM_TARGET  = 700;
    localparam int IDLE_CUTOFF  = 560;
    localparam int DRAIN_CYCLES = 300;

    logic      clk     = 1'b0;
    logic      rst_n   = 1'b0;
    logic      start   = 1'b0;
    in_item_t  in_item = '0;
    logic      busy;
    logic      done;
    out_item_t result;

    sha1_digest_scoreboard sb;
    int  items_sent;
    bit  idle_on;

    sha1_hash_engine_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_item (in_item),
        .done    (done),
        .result  (result)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check each digest at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_digest(result);
        end
    end

    function automatic in_item_t make_item(logic [7:0] b, logic hb, logic last);
        in_item_t it;
        it.data_byte = b;
        it.has_byte  = hb;
        it.last_item = last;
        return it;
    endfunction

    // Hold start high until the item transfers, then note it.
    task automatic send_item(in_item_t it);
        start   <= 1'b1;
        in_item <= it;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sb.note_item(it);
        if (it.has_byte || it.last_item)
        begin
            items_sent++;
        end
    endtask

    // Drop start for a random burst of idle cycles now and then.
    task automatic pace();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Send one message of len random bytes; end on the last byte or by a bare end item.
    task automatic send_message(int len, bit end_on_byte);
        for (int i = 0; i < len; i++)
        begin
            pace();
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
                pace();
            end
            send_item(make_item(8'($urandom_range(0, 255)), 1'b1,
                                (end_on_byte && i == len - 1) ? 1'b1 : 1'b0));
        end
        if (len == 0 || !end_on_byte)
        begin
            pace();
            send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        end
    endtask

    // Favor short messages, with a share near the padding and block boundaries.
    function automatic int pick_length();
        int boundary [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return $urandom_range(0, 12);
        end
        else if (r < 8)
        begin
            return boundary[$urandom_range(0, 9)];
        end
        return $urandom_range(0, 150);
    endfunction

    initial
    begin
        sb         = new();
        items_sent = 0;
        idle_on    = 1'b0;

        // Release reset.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, then noise that must be ignored.
        send_item(make_item(8'hA5, 1'b0, 1'b1));
        send_item(make_item(8'hFF, 1'b0, 1'b0));
        // "abc" ending with byte and end together.
        send_item(make_item(8'h61, 1'b1, 1'b0));
        send_item(make_item(8'h62, 1'b1, 1'b0));
        send_item(make_item(8'h63, 1'b1, 1'b1));
        // Extreme bytes, then end without a byte.
        send_item(make_item(8'h00, 1'b1, 1'b0));
        send_item(make_item(8'hFF, 1'b1, 1'b0));
        send_item(make_item(8'h5A, 1'b0, 1'b1));
        // Single-byte messages, one after noise.
        send_item(make_item(8'hFF, 1'b1, 1'b1));
        send_item(make_item(8'h00, 1'b0, 1'b0));
        send_item(make_item(8'h00, 1'b1, 1'b1));
        // Back-to-back empty messages.
        send_item(make_item(8'h00, 1'b0, 1'b1));
        send_item(make_item(8'hFF, 1'b0, 1'b1));

        // Random messages; no idling in the last part.
        idle_on = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= IDLE_CUTOFF)
            begin
                idle_on = 1'b0;
            end
            send_message(pick_length(), 1'($urandom_range(0, 1)));
        end
        start <= 1'b0;

        // Drain outstanding digests, then let the engine settle.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_drained();

        if (sb.mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
